// ----- src/three_phase_sine_generator_core_assert.svh -----
// Assertion helpers shared by the checker.
`ifndef THREE_PHASE_SINE_GENERATOR_CORE_ASSERT_SVH
`define THREE_PHASE_SINE_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TPSG_ASSERT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TPSG_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tpsg_pkg.sv -----
package tpsg_pkg;

  localparam int PHASE_BITS = 10;
  localparam int SINE_BITS  = 16;

  localparam int TIME_W = 32;
  localparam int FREQ_W = 30;
  localparam int AMP_W  = 24;
  localparam int OUT_W  = 24;
  localparam int CFG_W  = 30;
  localparam int CFG_IDX_W = 2;

  // product, rounded product after the shift, sum with offset
  localparam int PROD_W = SINE_BITS + AMP_W;
  localparam int SHR_W  = PROD_W - (SINE_BITS - 1);
  localparam int SUM_W  = SHR_W + 1;

  localparam int PIPE_DEPTH = 4;

  localparam int QUARTER = 2 ** (PHASE_BITS - 2);
  localparam int ADDR_W  = PHASE_BITS - 1;
  localparam int MAG_W   = SINE_BITS - 1;

  localparam logic [TIME_W-1:0] PHASE_V_SHIFT = 32'h5555_5555;
  localparam logic [TIME_W-1:0] PHASE_W_SHIFT = 32'hAAAA_AAAB;

  localparam logic [FREQ_W-1:0] FREQ_RST = FREQ_W'(3276800);
  localparam logic [AMP_W-1:0]  AMP_RST  = AMP_W'(65536);
  localparam logic [AMP_W-1:0]  OFS_RST  = '0;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQUENCY = 2'd0,
    CFG_AMPLITUDE = 2'd1,
    CFG_OFFSET    = 2'd2
  } cfg_reg_e;

  typedef logic signed [SINE_BITS-1:0] sine_t;
  typedef logic [MAG_W-1:0] qrom_t [QUARTER+1];

  typedef struct packed {
    logic mul;  // load product register
    logic sat;  // load result register
  } scale_en_t;

  // Quarter-wave magnitude table, Q30 Taylor series rounded to Q1.(SINE_BITS-1).
  function automatic qrom_t build_qrom();
    qrom_t rom;
    longint unsigned x;
    longint unsigned term;
    longint sum;
    longint v;
    longint scale;
    scale = longint'(1) << (SINE_BITS - 1);
    for (int r = 0; r <= QUARTER; r++) begin
      x = (longint'(r) * TWO_PI_Q30 + (64'd1 << (PHASE_BITS - 1))) >> PHASE_BITS;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        case (n)
          1: term = term / 64'd6;
          2: term = term / 64'd20;
          3: term = term / 64'd42;
          4: term = term / 64'd72;
          5: term = term / 64'd110;
          6: term = term / 64'd156;
          7: term = term / 64'd210;
          default: term = term / 64'd272;
        endcase
        if ((n % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum * scale + (longint'(1) << 29)) >>> 30;
      if (v > scale - 1) v = scale - 1;
      rom[r] = MAG_W'(v);
    end
    return rom;
  endfunction

  localparam qrom_t QROM = build_qrom();

  // Fold the phase into the quarter table and restore the sign.
  function automatic sine_t sine_lookup(input logic [TIME_W-1:0] phase);
    logic [PHASE_BITS-1:0] idx;
    logic [PHASE_BITS-3:0] r;
    logic [ADDR_W-1:0] addr;
    logic [MAG_W-1:0] mag;
    idx = phase[TIME_W-1 -: PHASE_BITS];
    r = idx[PHASE_BITS-3:0];
    if (idx[PHASE_BITS-2]) addr = ADDR_W'(QUARTER) - {1'b0, r};
    else addr = {1'b0, r};
    mag = QROM[addr];
    if (idx[PHASE_BITS-1]) return -sine_t'({1'b0, mag});
    return sine_t'({1'b0, mag});
  endfunction

endpackage

// ----- src/tpsg_time_if.sv -----
interface tpsg_time_if import tpsg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_seconds;

  modport source (output valid, output time_seconds, input ready);
  modport sink   (input valid, input time_seconds, output ready);
endinterface

// ----- src/tpsg_phase_if.sv -----
interface tpsg_phase_if import tpsg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] phase_u;
  logic signed [OUT_W-1:0] phase_v;
  logic signed [OUT_W-1:0] phase_w;

  modport source (output valid, output phase_u, output phase_v, output phase_w,
                  input ready);
  modport sink   (input valid, input phase_u, input phase_v, input phase_w,
                  output ready);
endinterface

// ----- src/three_phase_sine_generator_core.sv -----
// Three-phase sine generator.
//
// Input channel time_i carries one time stamp per beat (unsigned Q16.16 s).
// Output channel phase_o carries three signed Q8.16 samples per beat: U, V
// shifted by one third of a turn, W shifted by two thirds. Both channels use
// a valid/ready handshake; a beat moves when valid and ready are both high.
// Configuration is a write port: cfg_we_i with cfg_index_i selects frequency
// (0), amplitude (1) or offset (2); other indexes are dropped. Write only
// while no beat is in flight.
//
// Four register stages: phase multiply (32x30), sine table lookup, amplitude
// multiply per phase, round/offset/saturate. Throughput is one beat per cycle
// while phase_o.ready stays high, set by the single table read and single
// multiplier per phase in each stage.
//
// Reset clears all stage valid bits and loads frequency 50 Hz, amplitude 1.0
// and offset 0. When the receiver stalls, the output beat holds and the
// stages behind it keep filling bubbles; time_i.ready drops only once every
// stage holds a beat.
module three_phase_sine_generator_core import tpsg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  tpsg_time_if.sink            time_i,
  tpsg_phase_if.source         phase_o
);

  // configuration registers
  logic [FREQ_W-1:0]       freq_q;
  logic signed [AMP_W-1:0] amp_q;
  logic signed [AMP_W-1:0] ofs_q;

  // stage valid bits and ready chain
  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  // stage 1: phase of U in turns
  logic [TIME_W-1:0] ph_d, ph_q;

  // stage 2: signed sine samples
  sine_t sin_u_q, sin_v_q, sin_w_q;

  scale_en_t scale_en;

  // Write configuration; ignore indexes past the register list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FREQ_RST;
      amp_q  <= AMP_RST;
      ofs_q  <= OFS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FREQUENCY: freq_q <= cfg_data_i[FREQ_W-1:0];
        CFG_AMPLITUDE: amp_q  <= cfg_data_i[AMP_W-1:0];
        CFG_OFFSET:    ofs_q  <= cfg_data_i[AMP_W-1:0];
        default:       ;
      endcase
    end
  end

  // A stage advances when it is empty or the next one advances.
  assign r4 = !v4_q || phase_o.ready;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;

  assign time_i.ready = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= time_i.valid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  // Keep only the fractional turn: low 32 bits of the Q32.32 product.
  assign ph_d = TIME_W'(time_i.time_seconds * {{(TIME_W - FREQ_W){1'b0}}, freq_q});

  always_ff @(posedge clk_i) begin
    if (r1 && time_i.valid) ph_q <= ph_d;
    if (r2 && v1_q) begin
      sin_u_q <= sine_lookup(ph_q);
      sin_v_q <= sine_lookup(ph_q + PHASE_V_SHIFT);
      sin_w_q <= sine_lookup(ph_q + PHASE_W_SHIFT);
    end
  end

  // Stages 3 and 4 live in the per-phase scaler.
  assign scale_en.mul = r3 && v2_q;
  assign scale_en.sat = r4 && v3_q;

  tpsg_scale u_scale_u (
    .clk_i    (clk_i),
    .en_i     (scale_en),
    .sine_i   (sin_u_q),
    .amp_i    (amp_q),
    .offset_i (ofs_q),
    .result_o (phase_o.phase_u)
  );

  tpsg_scale u_scale_v (
    .clk_i    (clk_i),
    .en_i     (scale_en),
    .sine_i   (sin_v_q),
    .amp_i    (amp_q),
    .offset_i (ofs_q),
    .result_o (phase_o.phase_v)
  );

  tpsg_scale u_scale_w (
    .clk_i    (clk_i),
    .en_i     (scale_en),
    .sine_i   (sin_w_q),
    .amp_i    (amp_q),
    .offset_i (ofs_q),
    .result_o (phase_o.phase_w)
  );

  assign phase_o.valid = v4_q;

endmodule

// ----- src/tpsg_scale.sv -----
module tpsg_scale import tpsg_pkg::*; (
  input  logic                    clk_i,
  input  scale_en_t               en_i,
  input  sine_t                   sine_i,
  input  logic signed [AMP_W-1:0] amp_i,
  input  logic signed [AMP_W-1:0] offset_i,
  output logic signed [OUT_W-1:0] result_o
);

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (SINE_BITS - 2);

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [PROD_W-1:0] rnd;
  logic signed [SHR_W-1:0]  shr;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-OUT_W:0]     hi;
  logic signed [OUT_W-1:0]  res_d, res_q;

  assign prod_d = PROD_W'(sine_i) * PROD_W'(amp_i);

  // Round halves up, drop the sine fraction, add offset, clamp.
  always_comb begin
    rnd = prod_q + RND_HALF;
    shr = rnd[PROD_W-1 -: SHR_W];
    sum = {shr[SHR_W-1], shr} + {{(SUM_W - AMP_W){offset_i[AMP_W-1]}}, offset_i};
    hi  = sum[SUM_W-1:OUT_W-1];
    if ((&hi) || !(|hi)) res_d = sum[OUT_W-1:0];
    else res_d = {sum[SUM_W-1], {(OUT_W-1){~sum[SUM_W-1]}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) prod_q <= prod_d;
    if (en_i.sat) res_q <= res_d;
  end

  assign result_o = res_q;

endmodule

// ----- src/tpsg_checker.sv -----
`include "three_phase_sine_generator_core_assert.svh"

module tpsg_checker import tpsg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [OUT_W-1:0] out_u_i,
  input  logic signed [OUT_W-1:0] out_v_i,
  input  logic signed [OUT_W-1:0] out_w_i
);

  localparam int OCC_W = $clog2(PIPE_DEPTH + 1);

  logic             in_beat, out_beat;
  logic [OCC_W-1:0] occ_d, occ_q;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Track beats in flight.
  always_comb begin
    occ_d = occ_q;
    if (in_beat && !out_beat) occ_d = occ_q + OCC_W'(1);
    if (out_beat && !in_beat) occ_d = occ_q - OCC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  `TPSG_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "output beat dropped while stalled")
  `TPSG_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_u_i) && $stable(out_v_i) && $stable(out_w_i), "output payload changed while stalled")
  `TPSG_ASSERT(a_in_ready_free, clk_i, rst_ni, out_ready_i, in_ready_i, "input held off although output drains")
  `TPSG_ASSERT(a_out_occupancy, clk_i, rst_ni, out_valid_i, (occ_q != '0) && (occ_q <= OCC_W'(PIPE_DEPTH)), "output beat without matching input beat")

endmodule

bind three_phase_sine_generator_core tpsg_checker u_tpsg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (time_i.valid),
  .in_ready_i  (time_i.ready),
  .out_valid_i (phase_o.valid),
  .out_ready_i (phase_o.ready),
  .out_u_i     (phase_o.phase_u),
  .out_v_i     (phase_o.phase_v),
  .out_w_i     (phase_o.phase_w)
);

// ----- bench/tb_three_phase_sine_generator_core.sv -----
`timescale 1ns / 1ps

module tb_three_phase_sine_generator_core import tpsg_pkg::*; ();

  // Receiver hold-off long enough to fill every stage and stall the input.
  localparam int HOLD_CYCLES = 60;
  // Settle time after the last beat.
  localparam int TAIL_CYCLES = PIPE_DEPTH + 8;
  localparam int BLOCKS      = 15;
  localparam int BLOCK_ITEMS = 100;

  // Index 3 is not mapped; the block drops writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic [FREQ_W-1:0]        FREQ_ONE_HZ = FREQ_W'(65536);
  localparam logic [FREQ_W-1:0]        FREQ_TOP    = '1;
  localparam logic signed [AMP_W-1:0]  LEVEL_MAX   = 24'sh7FFFFF;
  localparam logic signed [AMP_W-1:0]  LEVEL_MIN   = 24'sh800000;

  typedef struct packed {
    logic signed [OUT_W-1:0] u;
    logic signed [OUT_W-1:0] v;
    logic signed [OUT_W-1:0] w;
  } sample_t;

  // Holds a private copy of the registers and the sine table, predicts the
  // three phase levels of each time stamp and checks the output beats in order.
  class phase_checker;
    localparam int QTR = 2 ** (PHASE_BITS - 2);
    localparam longint TOP = 8388607;
    localparam longint BOTTOM = -8388608;

    logic [FREQ_W-1:0]       freq;
    logic signed [AMP_W-1:0] amp;
    logic signed [AMP_W-1:0] ofs;
    int unsigned             mag [QTR+1];
    sample_t                 due [$];
    int                      errors;

    function new();
      freq = FREQ_RST;
      amp = AMP_RST;
      ofs = OFS_RST;
      errors = 0;
      for (int r = 0; r <= QTR; r++) mag[r] = quarter_mag(r);
    endfunction

    // Magnitude of sin(2*pi*r/(4*QTR)) from a Q30 Taylor series, rounded to the
    // table's fraction bits and clamped below the positive full scale.
    function int unsigned quarter_mag(int r);
      longint unsigned x;
      longint unsigned term;
      longint acc;
      longint v;
      longint full;
      full = longint'(1) << (SINE_BITS - 1);
      x = (64'(r) * 64'd6746518852 + (64'd1 << (PHASE_BITS - 1))) >> PHASE_BITS;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      v = (acc * full + (longint'(1) << 29)) >>> 30;
      if (v > full - 1) v = full - 1;
      return 32'(v);
    endfunction

    // Fold the top phase bits onto the quarter table; the upper half is negative.
    function int sine_of(logic [TIME_W-1:0] ph);
      logic [PHASE_BITS-1:0] idx;
      int r;
      int s;
      idx = ph[TIME_W-1 -: PHASE_BITS];
      r = int'(idx[PHASE_BITS-3:0]);
      s = idx[PHASE_BITS-2] ? int'(mag[QTR - r]) : int'(mag[r]);
      return idx[PHASE_BITS-1] ? -s : s;
    endfunction

    // Scale by amplitude, round half up, add offset, saturate.
    function logic signed [OUT_W-1:0] level_at(logic [TIME_W-1:0] ph);
      longint acc;
      acc = longint'(sine_of(ph)) * longint'(amp);
      acc = ((acc + (longint'(1) << (SINE_BITS - 2))) >>> (SINE_BITS - 1)) + longint'(ofs);
      if (acc > TOP) acc = TOP;
      if (acc < BOTTOM) acc = BOTTOM;
      return acc[OUT_W-1:0];
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_FREQUENCY: freq = data[FREQ_W-1:0];
        CFG_AMPLITUDE: amp = data[AMP_W-1:0];
        CFG_OFFSET:    ofs = data[AMP_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_stamp(logic [TIME_W-1:0] t);
      logic [63:0]       turns;
      logic [TIME_W-1:0] pu;
      sample_t           s;
      turns = 64'(t) * 64'(freq);
      pu = turns[TIME_W-1:0];
      s.u = level_at(pu);
      s.v = level_at(pu + PHASE_V_SHIFT);
      s.w = level_at(pu + PHASE_W_SHIFT);
      due.push_back(s);
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      if (due.size() == 0) begin
        $error("output beat with no time stamp pending: u=%0d v=%0d w=%0d",
               got.u, got.v, got.w);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.u !== want.u) begin
        $error("phase_u: expected %0d, actual %0d", want.u, got.u);
        errors++;
      end
      if (got.v !== want.v) begin
        $error("phase_v: expected %0d, actual %0d", want.v, got.v);
        errors++;
      end
      if (got.w !== want.w) begin
        $error("phase_w: expected %0d, actual %0d", want.w, got.w);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  tpsg_time_if  time_ch ();
  tpsg_phase_if phase_ch ();

  three_phase_sine_generator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .time_i      (time_ch),
    .phase_o     (phase_ch)
  );

  phase_checker board;

  // Receiver behavior, set by the stimulus per block:
  // 0 always ready, 1 coin flip, 2 rare stalls, 3 periodic stalls.
  int rx_style = 0;
  // Each increment asks the receiver for one long hold-off.
  int holds_asked = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops beats.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Sample the output channel at each edge; beats move on valid and ready.
  always @(posedge clk_i) begin
    if (rst_ni && phase_ch.valid && phase_ch.ready) begin
      board.check_sample({phase_ch.phase_u, phase_ch.phase_v, phase_ch.phase_w});
    end
  end

  // Receiver: compute the next ready once per edge and drive it once.
  initial begin
    int  hold_left;
    int  served;
    int  cyc;
    logic nxt;
    hold_left = 0;
    served = 0;
    cyc = 0;
    phase_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      // Pick up a new hold-off request and count it down locally.
      if (served < holds_asked) begin
        served++;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_ni) begin
        nxt = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else begin
        case (rx_style)
          0:       nxt = 1'b1;
          1:       nxt = 1'($urandom_range(0, 1));
          2:       nxt = ($urandom_range(0, 7) != 0);
          default: nxt = (cyc % 3 != 0);
        endcase
      end
      phase_ch.ready <= nxt;
    end
  end

  // Offer one time stamp and hold it until the block takes it.
  task automatic push_stamp(input logic [TIME_W-1:0] t);
    time_ch.valid <= 1'b1;
    time_ch.time_seconds <= t;
    do @(posedge clk_i); while (!time_ch.ready);
    board.note_stamp(t);
  endtask

  // Drop valid for the given pause; scramble the idle payload so it must be ignored.
  task automatic pause_tx(input int n);
    time_ch.valid <= 1'b0;
    time_ch.time_seconds <= $urandom();
    repeat (n) @(posedge clk_i);
  endtask

  // Wait until every predicted sample has come out.
  task automatic settle();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Write one register; write enable stays high across back-to-back writes.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  // Load all three registers plus a junk write to the unmapped index.
  task automatic load_setting(input logic [FREQ_W-1:0] f,
                              input logic signed [AMP_W-1:0] a,
                              input logic signed [AMP_W-1:0] o);
    put_reg(CFG_FREQUENCY, CFG_W'(f));
    put_reg(CFG_AMPLITUDE, {{(CFG_W-AMP_W){a[AMP_W-1]}}, a});
    put_reg(CFG_OFFSET, {{(CFG_W-AMP_W){o[AMP_W-1]}}, o});
    put_reg(CFG_SPARE, CFG_W'($urandom()));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Directed run: optional register load, then n evenly spaced time stamps
  // back to back, then drain.
  task automatic directed_run(input bit reload, input logic [FREQ_W-1:0] f,
                              input logic signed [AMP_W-1:0] a,
                              input logic signed [AMP_W-1:0] o,
                              input logic [TIME_W-1:0] t0,
                              input logic [TIME_W-1:0] stride, input int n);
    if (reload) load_setting(f, a, o);
    for (int k = 0; k < n; k++) push_stamp(t0 + TIME_W'(k) * stride);
    pause_tx(1);
    settle();
  endtask

  // Amplitude and offset picks: extremes, near zero, zero, anything.
  function automatic logic [AMP_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return LEVEL_MAX;
      1:       return LEVEL_MIN;
      2:       return AMP_W'(int'($urandom_range(0, 131072)) - 65536);
      3:       return '0;
      default: return AMP_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [FREQ_W-1:0] f;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] stride;
    bit                sweep;
    bit                gappy;
    int                burst;

    board = new();
    time_ch.valid <= 1'b0;
    time_ch.time_seconds <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_FREQUENCY;
    cfg_data_i <= '0;

    // Hold reset, then release it once for the whole run.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: zero time, all-ones time and two points between.
    directed_run(1'b0, FREQ_RST, AMP_RST, OFS_RST, '0, 32'h5555_5555, 4);
    // One hertz: the low time bits step through the eighths of a turn,
    // hitting both peaks and both zero crossings at full positive amplitude.
    directed_run(1'b1, FREQ_ONE_HZ, LEVEL_MAX, '0, '0, 32'h0000_2000, 8);
    // Most negative amplitude with top offset: clip high at the trough.
    directed_run(1'b1, FREQ_ONE_HZ, LEVEL_MIN, LEVEL_MAX, 32'h0000_4000, 32'h0000_8000, 2);
    // Top amplitude with bottom offset: clip low at the trough.
    directed_run(1'b1, FREQ_ONE_HZ, LEVEL_MAX, LEVEL_MIN, 32'h0000_4000, 32'h0000_8000, 2);
    // Zero frequency: phase pinned, outputs follow the fixed phase shifts.
    directed_run(1'b1, '0, AMP_W'($urandom()), AMP_W'($urandom()), $urandom(), $urandom(), 3);
    // Zero amplitude: every output is the offset.
    directed_run(1'b1, FREQ_W'($urandom()), '0, AMP_W'($urandom()), $urandom(), $urandom(), 3);
    // Largest frequency with time wrapping through the top.
    directed_run(1'b1, FREQ_TOP, AMP_RST, OFS_RST, 32'hFFFF_FFFF, 32'h0000_0001, 3);

    for (int blk = 0; blk < BLOCKS; blk++) begin
      case ($urandom_range(0, 7))
        0:       f = FREQ_W'(1);
        1:       f = FREQ_TOP;
        2:       f = FREQ_W'(655360000);
        3:       f = '0;
        4, 5:    f = FREQ_W'($urandom_range(1, 65536 * 400));
        default: f = FREQ_W'($urandom());
      endcase
      load_setting(f, pick_level(), pick_level());

      // Rotate receiver styles and sender gaps so bubbles land on every stage.
      rx_style = blk % 4;
      gappy = (blk % 3) != 0;
      // A coin flip per block picks sweeping time like a real tick source or jumping around.
      sweep = 1'($urandom_range(0, 1));
      t = $urandom();
      stride = TIME_W'($urandom_range(1, 32'h0002_0000));
      burst = $urandom_range(1, 12);

      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        // In gapless blocks, stall the receiver hard while beats keep coming.
        if (blk % 6 == 0 && k == 30) holds_asked++;
        push_stamp(sweep ? t : $urandom());
        t += stride;
        if (gappy) begin
          if (burst == 0) begin
            pause_tx($urandom_range(1, 6));
            burst = $urandom_range(1, 12);
          end else begin
            burst--;
          end
        end
      end
      // Stop offering and wait for the block to drain before the next setting.
      pause_tx(1);
      settle();
    end

    // Let any stray beat surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
